### design/input_capture_pwm_measure_top_defines.svh
// Assertion helpers used by icpm_back.
`ifndef INPUT_CAPTURE_PWM_MEASURE_TOP_DEFINES_SVH
`define INPUT_CAPTURE_PWM_MEASURE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ICPM_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
`define ICPM_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);
`else
`define ICPM_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define ICPM_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg)
`endif

`endif

### design/icpm_pkg.sv
`default_nettype none

package icpm_pkg;

    localparam int CAP_W       = 16;
    localparam int TICK_W      = 8;
    localparam int TIME_W      = 24;
    localparam int DUTY_W      = 7;
    localparam int OUT_DATA_W  = 80;
    localparam int OUT_USER_W  = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DUTY_W-1:0] FULL_DUTY  = 7'd100;
    localparam logic [TICK_W-1:0] TICK_RESET = 8'd1;

    // step counter value for the range/zero check ahead of the quotient bits
    localparam logic [2:0] DIV_CHECK_STEP = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_DIV   = 5'b00100,
        S_SCALE = 5'b01000,
        S_DONE  = 5'b10000
    } back_state_t;

    // control part of a queued word
    typedef struct packed {
        logic measure;       // rising edge: new period/high come along
        logic next_falling;  // phase after this capture
    } icpm_ctl_t;

    localparam int CTL_W = $bits(icpm_ctl_t);

endpackage

`default_nettype wire

### design/input_capture_pwm_measure_top.sv
// A rising-edge capture is popped, gets its duty product, a range/zero check and
// 7 quotient steps, then the shared tick multiplier scales period, high and low in
// turn and the output load raises m_tvalid; a saturating duty or zero period skips
// the quotient steps, a falling-edge capture goes from pop straight to scaling. One
// word is handled at a time; a 2-word queue buffers captures and low m_tready stalls.
// Reset (rst_n, async, active low): awaiting rising edge, stamps and duty zero, tick 1.
`default_nettype none

module input_capture_pwm_measure_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [15:0] capture_value
    input  wire logic [icpm_pkg::CAP_W-1:0]         s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [23:0] period_time, [47:24] high_time, [71:48] low_time, [78:72] duty_percent
    output logic [icpm_pkg::OUT_DATA_W-1:0]         m_tdata,
    // [0] zero_period, [1] next_edge_falling
    output logic [icpm_pkg::OUT_USER_W-1:0]         m_tuser,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [icpm_pkg::TICK_W-1:0]        cfg_data
);
    import icpm_pkg::*;

    localparam int QW = CTL_W + 2 * COUNT_WIDTH;

    logic          q_ready;
    logic          q_push;
    logic [QW-1:0] q_push_data;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_data;

    assign cfg_ready = 1'b1;

    icpm_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_push_data(q_push_data)
    );

    icpm_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_push_data),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .data     (q_data)
    );

    icpm_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_valid && cfg_ready),
        .cfg_data(cfg_data),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

`default_nettype wire

### design/icpm_front.sv
`default_nettype none

module icpm_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       s_tvalid,
    output logic                                            s_tready,
    input  wire logic [icpm_pkg::CAP_W-1:0]                 s_tdata,
    input  wire logic                                       q_ready,
    output logic                                            q_push,
    output logic [icpm_pkg::CTL_W+2*COUNT_WIDTH-1:0]        q_push_data
);
    import icpm_pkg::*;

    logic                   phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] start_reg, start_next;
    logic [COUNT_WIDTH-1:0] stop_reg, stop_next;
    logic [COUNT_WIDTH-1:0] cap;
    logic [COUNT_WIDTH-1:0] period_ticks;
    logic [COUNT_WIDTH-1:0] high_ticks;
    icpm_ctl_t              ctl;
    logic                   accept;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;
    assign cap      = COUNT_WIDTH'(s_tdata);

    // differences wrap modulo 2^COUNT_WIDTH
    assign period_ticks = cap - start_reg;
    assign high_ticks   = stop_reg - start_reg;

    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        stop_next  = stop_reg;
        ctl.measure      = !phase_reg;
        ctl.next_falling = !phase_reg;
        if (accept)
        begin
            phase_next = !phase_reg;
            if (!phase_reg)
            begin
                start_next = cap;
            end
            else
            begin
                stop_next = cap;
            end
        end
    end

    assign q_push      = accept;
    assign q_push_data = {ctl, period_ticks, high_ticks};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            start_reg <= '0;
            stop_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

`default_nettype wire

### design/icpm_queue.sv
`default_nettype none

module icpm_queue #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  ready,
    input  wire logic             pop,
    output logic                  valid,
    output logic [WIDTH-1:0]      data
);
    import icpm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign ready   = count_reg != CW'(DEPTH);
    assign valid   = count_reg != '0;
    assign data    = slot_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/icpm_back.sv
`default_nettype none

`include "input_capture_pwm_measure_top_defines.svh"

module icpm_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      cfg_we,
    input  wire logic [icpm_pkg::TICK_W-1:0]               cfg_data,
    input  wire logic                                      q_valid,
    input  wire logic [icpm_pkg::CTL_W+2*COUNT_WIDTH-1:0]  q_data,
    output logic                                           q_pop,
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    output logic [icpm_pkg::OUT_DATA_W-1:0]                m_tdata,
    output logic [icpm_pkg::OUT_USER_W-1:0]                m_tuser
);
    import icpm_pkg::*;

    localparam int DW = COUNT_WIDTH + DUTY_W;
    localparam int PW = COUNT_WIDTH + TICK_W;
    localparam int PAD_W = OUT_DATA_W - 3 * TIME_W - DUTY_W;

    back_state_t            state_reg, state_next;
    logic [2:0]             step_reg, step_next;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [COUNT_WIDTH-1:0] period_reg, period_next;
    logic [COUNT_WIDTH-1:0] high_reg, high_next;
    logic [DUTY_W-1:0]      duty_reg, duty_next;
    logic                   falling_reg, falling_next;
    logic [DW-1:0]          num_reg, num_next;
    logic [DUTY_W-1:0]      quo_reg, quo_next;
    logic [TIME_W-1:0]      per_t_reg, per_t_next;
    logic [TIME_W-1:0]      high_t_reg, high_t_next;
    logic [TIME_W-1:0]      low_t_reg, low_t_next;
    logic                   out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]      out_per_reg, out_high_reg, out_low_reg;
    logic [DUTY_W-1:0]      out_duty_reg;
    logic                   out_zero_reg, out_falling_reg;
    logic                   out_load;

    icpm_ctl_t              q_ctl;
    logic [COUNT_WIDTH-1:0] q_period;
    logic [COUNT_WIDTH-1:0] q_high;
    logic [COUNT_WIDTH-1:0] diff_ticks;
    logic [COUNT_WIDTH-1:0] mul_src;
    logic [PW-1:0]          prod;
    logic [DW-1:0]          num_prod;
    logic [DW-1:0]          div_shift;
    logic [DW:0]            trial;
    logic                   fits;
    logic                   sat_hit;
    logic [DUTY_W-1:0]      quo_new;

    assign {q_ctl, q_period, q_high} = q_data;

    assign diff_ticks = period_reg - high_reg;
    assign num_prod   = DW'(high_reg) * DW'(FULL_DUTY);
    // quotient would not fit in 7 bits: well past 100
    assign sat_hit    = num_reg >= {period_reg, {DUTY_W{1'b0}}};
    assign div_shift  = DW'(period_reg) << step_reg;
    assign trial      = {1'b0, num_reg} - {1'b0, div_shift};
    assign fits       = !trial[DW];
    assign quo_new    = fits ? (quo_reg | (DUTY_W'(1) << step_reg)) : quo_reg;

    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:    mul_src = period_reg;
            2'd1:    mul_src = high_reg;
            default: mul_src = diff_ticks;
        endcase
    end

    assign prod = PW'(mul_src) * PW'(tick_reg);

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        tick_next    = cfg_we ? cfg_data : tick_reg;
        period_next  = period_reg;
        high_next    = high_reg;
        duty_next    = duty_reg;
        falling_next = falling_reg;
        num_next     = num_reg;
        quo_next     = quo_reg;
        per_t_next   = per_t_reg;
        high_t_next  = high_t_reg;
        low_t_next   = low_t_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    falling_next = q_ctl.next_falling;
                    step_next    = '0;
                    if (q_ctl.measure)
                    begin
                        period_next = q_period;
                        high_next   = q_high;
                        state_next  = S_MUL;
                    end
                    else
                    begin
                        state_next = S_SCALE;
                    end
                end
            end
            S_MUL:
            begin
                num_next   = num_prod;
                step_next  = DIV_CHECK_STEP;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == DIV_CHECK_STEP)
                begin
                    quo_next = '0;
                    if (period_reg == '0)
                    begin
                        duty_next  = '0;
                        step_next  = '0;
                        state_next = S_SCALE;
                    end
                    else if (sat_hit)
                    begin
                        duty_next  = FULL_DUTY;
                        step_next  = '0;
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        step_next = step_reg - 1'b1;
                    end
                end
                else
                begin
                    quo_next = quo_new;
                    if (fits)
                    begin
                        num_next = trial[DW-1:0];
                    end
                    if (step_reg == '0)
                    begin
                        duty_next  = (quo_new > FULL_DUTY) ? FULL_DUTY : quo_new;
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        step_next = step_reg - 1'b1;
                    end
                end
            end
            S_SCALE:
            begin
                // one shared multiplier: period, high, low in turn
                unique case (step_reg[1:0])
                    2'd0:    per_t_next  = TIME_W'(prod);
                    2'd1:    high_t_next = TIME_W'(prod);
                    default: low_t_next  = TIME_W'(prod);
                endcase
                if (step_reg == 3'd2)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        per_t_reg  <= per_t_next;
        high_t_reg <= high_t_next;
        low_t_reg  <= low_t_next;
        if (out_load)
        begin
            out_per_reg     <= per_t_reg;
            out_high_reg    <= high_t_reg;
            out_low_reg     <= low_t_reg;
            out_duty_reg    <= duty_reg;
            out_zero_reg    <= period_reg == '0;
            out_falling_reg <= falling_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            tick_reg      <= TICK_RESET;
            period_reg    <= '0;
            high_reg      <= '0;
            duty_reg      <= '0;
            falling_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            tick_reg      <= tick_next;
            period_reg    <= period_next;
            high_reg      <= high_next;
            duty_reg      <= duty_next;
            falling_reg   <= falling_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_duty_reg, out_low_reg, out_high_reg, out_per_reg};
    assign m_tuser  = {out_falling_reg, out_zero_reg};

    `ICPM_ASSERT_NEVER(a_duty_range, clk, rst_n, duty_reg > FULL_DUTY, "duty above 100")
    `ICPM_ASSERT(a_zero_duty, clk, rst_n, (state_reg == S_IDLE && period_reg == '0) |-> duty_reg == '0, "zero period with nonzero duty")
    `ICPM_ASSERT(a_load_src, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_DONE), "result word not from done state")
    `ICPM_ASSERT(a_out_zero, clk, rst_n, (out_valid_reg && out_zero_reg) |-> out_duty_reg == '0, "zero period word with duty")

endmodule

`default_nettype wire
